### rtl/fcull_pkg.sv
// Shared types and constants for the frustum culling core.
// Holds the item, plane and cell-to-cell bus types and the field widths.
// Used by fcull_cell and frustum_cull_sphere_aabb_core; depends on nothing.
package fcull_pkg;

	// Planes that are tested, and plane registers that exist.
	localparam int NUM_PLANES = 6;
	localparam int PLANE_REGS = 6;

	// Configuration port.
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 6;
	localparam int REG_IDX_W = 3;
	localparam int REG_LSB   = 3;

	// Field widths.
	localparam int COORD_W  = 24;
	localparam int RADIUS_W = 23;
	localparam int NORM_W   = 12;
	localparam int DIST_W   = 28;

	// Q.18 alignment of distance and radius against the products.
	localparam int ALIGN_W = 10;
	localparam int PROD_W  = NORM_W + COORD_W;
	localparam int BIAS_W  = DIST_W + 1 + ALIGN_W;
	localparam int SUM_W   = BIAS_W + 2;

	localparam logic MODE_SPHERE = 1'b0;
	localparam logic MODE_BOX    = 1'b1;

	typedef struct packed {
		logic                       mode;
		logic signed [COORD_W-1:0]  point_a_x;
		logic signed [COORD_W-1:0]  point_a_y;
		logic signed [COORD_W-1:0]  point_a_z;
		logic signed [COORD_W-1:0]  point_b_x;
		logic signed [COORD_W-1:0]  point_b_y;
		logic signed [COORD_W-1:0]  point_b_z;
		logic        [RADIUS_W-1:0] radius;
	} item_t;

	// Packed plane register: distance on top, then normal z, y, x.
	typedef struct packed {
		logic signed [DIST_W-1:0] distance;
		logic signed [NORM_W-1:0] nz;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nx;
	} plane_t;

	// What one cell hands to the next: the request and its running verdict.
	typedef struct packed {
		logic  vis;
		item_t item;
	} cell_bus_t;

endpackage

### rtl/frustum_cull_sphere_aabb_core.sv
// Top level of the frustum culling core: plane registers, APB port, cell chain.
// Instantiates fcull_cell once per tested plane; depends on fcull_pkg.
//
// The core tests each sphere or axis-aligned box request against the
// configured frustum planes and returns one visible flag per request, in
// order. Requests flow through a chain of NUM_PLANES identical cells, one
// per plane; each cell has a product stage (three 12 x 24 bit multiplies,
// the positive vertex chosen by the signs of the normal) and a sum stage
// (dot product plus distance, plus radius for spheres, compared with zero),
// so a request passes both stages of every cell in turn, and a new request
// can be accepted in every cycle while a stage has room. Each stage has
// its own valid bit and loads whenever it is empty or draining, so holes in
// the stream close up and in_ready stays high while a finished result waits
// at the output, as long as some stage upstream has room. Planes sit in six
// 64-bit registers at byte addresses 0, 8, 16, 24, 32 and 40 (left, right,
// bottom, top, near, far); each packs normal x, y and z as Q1.10 in bits
// 11:0, 23:12 and 35:24 and the distance as Q20.8 in bits 63:36. They reset
// to zero, and an all-zero plane culls nothing. Writes elsewhere are ignored
// and read back as zero. Planes should be written only while no request is
// in flight, since the cells read the registers directly.
module frustum_cull_sphere_aabb_core (
	input  logic                                  clk,
	input  logic                                  arst_n,

	// APB configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fcull_pkg::ADDR_W-1:0]          paddr,
	input  logic [fcull_pkg::DATA_W-1:0]          pwdata,
	output logic [fcull_pkg::DATA_W-1:0]          prdata,
	output logic                                  pready,

	// Request channel.
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  mode,
	input  logic signed [fcull_pkg::COORD_W-1:0]  point_a_x,
	input  logic signed [fcull_pkg::COORD_W-1:0]  point_a_y,
	input  logic signed [fcull_pkg::COORD_W-1:0]  point_a_z,
	input  logic signed [fcull_pkg::COORD_W-1:0]  point_b_x,
	input  logic signed [fcull_pkg::COORD_W-1:0]  point_b_y,
	input  logic signed [fcull_pkg::COORD_W-1:0]  point_b_z,
	input  logic        [fcull_pkg::RADIUS_W-1:0] radius,

	// Result channel.
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  visible
);

	logic [fcull_pkg::DATA_W-1:0]    planes_q [fcull_pkg::PLANE_REGS];
	logic [fcull_pkg::REG_IDX_W-1:0] reg_idx;
	logic                            reg_wr;

	logic                            valid_c [fcull_pkg::NUM_PLANES+1];
	logic                            ready_c [fcull_pkg::NUM_PLANES+1];
	fcull_pkg::cell_bus_t            bus_c   [fcull_pkg::NUM_PLANES+1];

	// Registers are eight bytes apart; the low address bits are not decoded.
	assign reg_idx = paddr[fcull_pkg::ADDR_W-1:fcull_pkg::REG_LSB];
	assign reg_wr  = psel && penable && pwrite &&
	                 (reg_idx < fcull_pkg::REG_IDX_W'(fcull_pkg::PLANE_REGS));
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fcull_pkg::PLANE_REGS; i++) begin
				planes_q[i] <= '0;
			end
		end else if (reg_wr) begin
			planes_q[reg_idx] <= pwdata;
		end
	end

	always_comb begin
		if (reg_idx < fcull_pkg::REG_IDX_W'(fcull_pkg::PLANE_REGS)) begin
			prdata = planes_q[reg_idx];
		end else begin
			prdata = '0;
		end
	end

	// Head of the chain: every request starts out visible.
	assign valid_c[0]                = in_valid;
	assign in_ready                  = ready_c[0];
	assign bus_c[0].vis              = 1'b1;
	assign bus_c[0].item.mode        = mode;
	assign bus_c[0].item.point_a_x   = point_a_x;
	assign bus_c[0].item.point_a_y   = point_a_y;
	assign bus_c[0].item.point_a_z   = point_a_z;
	assign bus_c[0].item.point_b_x   = point_b_x;
	assign bus_c[0].item.point_b_y   = point_b_y;
	assign bus_c[0].item.point_b_z   = point_b_z;
	assign bus_c[0].item.radius      = radius;

	for (genvar g = 0; g < fcull_pkg::NUM_PLANES; g++) begin : g_cell
		fcull_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.plane   (fcull_pkg::plane_t'(planes_q[g])),
			.valid_i (valid_c[g]),
			.bus_i   (bus_c[g]),
			.ready_o (ready_c[g]),
			.valid_o (valid_c[g+1]),
			.bus_o   (bus_c[g+1]),
			.ready_i (ready_c[g+1])
		);
	end

	// The last cell's sum stage is the output register.
	assign ready_c[fcull_pkg::NUM_PLANES] = out_ready;
	assign out_valid                      = valid_c[fcull_pkg::NUM_PLANES];
	assign visible                        = bus_c[fcull_pkg::NUM_PLANES].vis;

endmodule

### rtl/fcull_cell.sv
// One plane cell of the culling chain: a product stage and a sum stage.
// Tests the passing request against its plane and folds the result into vis.
// Depends on fcull_pkg.
module fcull_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcull_pkg::plane_t    plane,
	input  logic                 valid_i,
	input  fcull_pkg::cell_bus_t bus_i,
	output logic                 ready_o,
	output logic                 valid_o,
	output fcull_pkg::cell_bus_t bus_o,
	input  logic                 ready_i
);

	logic en1;
	logic en2;

	logic                                   box;
	logic signed [fcull_pkg::COORD_W-1:0]   px;
	logic signed [fcull_pkg::COORD_W-1:0]   py;
	logic signed [fcull_pkg::COORD_W-1:0]   pz;
	logic signed [fcull_pkg::PROD_W-1:0]    prod_x_c;
	logic signed [fcull_pkg::PROD_W-1:0]    prod_y_c;
	logic signed [fcull_pkg::PROD_W-1:0]    prod_z_c;
	logic signed [fcull_pkg::DIST_W:0]      dist_ext;
	logic signed [fcull_pkg::DIST_W:0]      rad_ext;
	logic signed [fcull_pkg::DIST_W:0]      bias_sum_c;
	logic signed [fcull_pkg::BIAS_W-1:0]    bias_c;

	logic                                   valid_s1;
	fcull_pkg::cell_bus_t                   bus_s1;
	logic signed [fcull_pkg::PROD_W-1:0]    prod_x_s1;
	logic signed [fcull_pkg::PROD_W-1:0]    prod_y_s1;
	logic signed [fcull_pkg::PROD_W-1:0]    prod_z_s1;
	logic signed [fcull_pkg::BIAS_W-1:0]    bias_s1;

	logic signed [fcull_pkg::SUM_W-1:0]     total_c;

	logic                                   valid_s2;
	fcull_pkg::cell_bus_t                   bus_s2;

	// A stage loads when it is empty or its contents move on.
	assign en2     = !valid_s2 || ready_i;
	assign en1     = !valid_s1 || en2;
	assign ready_o = en1;

	// Positive vertex: max corner where the normal component is not negative.
	assign box = (bus_i.item.mode == fcull_pkg::MODE_BOX);
	assign px  = (box && !plane.nx[fcull_pkg::NORM_W-1]) ? bus_i.item.point_b_x
	                                                    : bus_i.item.point_a_x;
	assign py  = (box && !plane.ny[fcull_pkg::NORM_W-1]) ? bus_i.item.point_b_y
	                                                    : bus_i.item.point_a_y;
	assign pz  = (box && !plane.nz[fcull_pkg::NORM_W-1]) ? bus_i.item.point_b_z
	                                                    : bus_i.item.point_a_z;

	assign prod_x_c = plane.nx * px;
	assign prod_y_c = plane.ny * py;
	assign prod_z_c = plane.nz * pz;

	assign dist_ext   = {plane.distance[fcull_pkg::DIST_W-1], plane.distance};
	assign rad_ext    = {{(fcull_pkg::DIST_W + 1 - fcull_pkg::RADIUS_W){1'b0}},
	                     bus_i.item.radius};
	assign bias_sum_c = box ? dist_ext : dist_ext + rad_ext;
	assign bias_c     = {bias_sum_c, {fcull_pkg::ALIGN_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			bus_s1    <= bus_i;
			prod_x_s1 <= prod_x_c;
			prod_y_s1 <= prod_y_c;
			prod_z_s1 <= prod_z_c;
			bias_s1   <= bias_c;
		end
	end

	assign total_c =
		{{(fcull_pkg::SUM_W - fcull_pkg::PROD_W){prod_x_s1[fcull_pkg::PROD_W-1]}}, prod_x_s1} +
		{{(fcull_pkg::SUM_W - fcull_pkg::PROD_W){prod_y_s1[fcull_pkg::PROD_W-1]}}, prod_y_s1} +
		{{(fcull_pkg::SUM_W - fcull_pkg::PROD_W){prod_z_s1[fcull_pkg::PROD_W-1]}}, prod_z_s1} +
		{{(fcull_pkg::SUM_W - fcull_pkg::BIAS_W){bias_s1[fcull_pkg::BIAS_W-1]}}, bias_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	// A negative sum puts the object wholly behind this plane.
	always_ff @(posedge clk) begin
		if (en2) begin
			bus_s2.vis  <= bus_s1.vis & ~total_c[fcull_pkg::SUM_W-1];
			bus_s2.item <= bus_s1.item;
		end
	end

	assign valid_o = valid_s2;
	assign bus_o   = bus_s2;

endmodule

### rtl/fcull_sva.sv
// Port-level checks for the frustum culling core, bound to its top level.
// Depends on fcull_pkg and frustum_cull_sphere_aabb_core.
module fcull_sva (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  psel,
	input logic                                  penable,
	input logic                                  pwrite,
	input logic [fcull_pkg::ADDR_W-1:0]          paddr,
	input logic [fcull_pkg::DATA_W-1:0]          pwdata,
	input logic [fcull_pkg::DATA_W-1:0]          prdata,
	input logic                                  pready,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  mode,
	input logic signed [fcull_pkg::COORD_W-1:0]  point_a_x,
	input logic signed [fcull_pkg::COORD_W-1:0]  point_a_y,
	input logic signed [fcull_pkg::COORD_W-1:0]  point_a_z,
	input logic signed [fcull_pkg::COORD_W-1:0]  point_b_x,
	input logic signed [fcull_pkg::COORD_W-1:0]  point_b_y,
	input logic signed [fcull_pkg::COORD_W-1:0]  point_b_z,
	input logic        [fcull_pkg::RADIUS_W-1:0] radius,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic                                  visible
);

	// No result is shown in the cycle after reset has been applied.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	// A stalled result holds its verdict.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(visible))
		else $error("stalled result dropped or changed");

	// A waiting request stays offered with its fields unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(mode) &&
		$stable(point_a_x) && $stable(point_a_y) && $stable(point_a_z) &&
		$stable(point_b_x) && $stable(point_b_y) && $stable(point_b_z) &&
		$stable(radius))
		else $error("waiting request withdrawn or changed");

	// With the output stage empty the whole chain can move, so a request is taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with an empty output stage");

	// The left plane register, written in one access, reads back at the next cycle.
	a_plane_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr == '0) |=>
		(paddr != '0) || (prdata == $past(pwdata)))
		else $error("left plane did not read back as written");

endmodule

bind frustum_cull_sphere_aabb_core fcull_sva u_fcull_sva (.*);

### dv/frustum_cull_sphere_aabb_core_test.sv
// Self-checking testbench for frustum_cull_sphere_aabb_core: APB plane set-up,
// directed sphere and box requests, then random streams checked in order.
// Depends on fcull_pkg and the core only.
`timescale 1ns / 100ps

module frustum_cull_sphere_aabb_core_test;

	// Plane register indexes; the last two lie beyond the register file and
	// must be ignored by the core.
	typedef enum int {
		REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP, REG_NEAR, REG_FAR,
		REG_HOLE_0, REG_HOLE_1
	} plane_reg_t;

	typedef logic signed [fcull_pkg::COORD_W-1:0] coord_t;

	localparam int IDLE_PCT    = 26;                 // idle cycles per hundred
	localparam int DRAIN_CYCLES = 2 * fcull_pkg::NUM_PLANES + 8; // depth and margin
	localparam int UNIT        = 256;                // 1.0 in Q16.8
	localparam int NORM_ONE    = 1024;               // 1.0 in Q1.10
	localparam int HALF_SIDE   = 1000 * UNIT;        // half width of the test cube
	localparam int COORD_MAX   = (1 << (fcull_pkg::COORD_W - 1)) - 1;
	localparam int COORD_MIN   = -(1 << (fcull_pkg::COORD_W - 1));
	localparam int RADIUS_MAX  = (1 << fcull_pkg::RADIUS_W) - 1;
	localparam int DIST_MAX    = (1 << (fcull_pkg::DIST_W - 1)) - 1;
	localparam int DIST_MIN    = -(1 << (fcull_pkg::DIST_W - 1));
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 90;

	// Every input of the core starts at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [fcull_pkg::ADDR_W-1:0] paddr = '0;
	logic [fcull_pkg::DATA_W-1:0] pwdata = '0;
	logic [fcull_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = fcull_pkg::MODE_SPHERE;
	coord_t point_a_x = '0;
	coord_t point_a_y = '0;
	coord_t point_a_z = '0;
	coord_t point_b_x = '0;
	coord_t point_b_y = '0;
	coord_t point_b_z = '0;
	logic [fcull_pkg::RADIUS_W-1:0] radius = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic visible;

	// Our own copy of the plane registers, the verdicts still owed by the core,
	// and a flag that switches idling off on both sides for a calm stretch.
	fcull_pkg::plane_t plane_regs[fcull_pkg::PLANE_REGS];
	logic visible_q[$];
	bit calm = 1'b0;
	int mismatch_count = 0;
	int result_count = 0;

	frustum_cull_sphere_aabb_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.point_a_x(point_a_x),
		.point_a_y(point_a_y),
		.point_a_z(point_a_z),
		.point_b_x(point_b_x),
		.point_b_y(point_b_y),
		.point_b_z(point_b_z),
		.radius   (radius),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.visible  (visible)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Generous ceiling on the length of a run.
	initial begin
		#2ms;
		$display("frustum_cull_sphere_aabb_core_test: done, errors");
		$finish;
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Predicted verdict for one request against the current planes. Each sum
	// is formed at 64 bits, which is far more than the 41 bits it can need, so
	// the comparison with zero is exact. A zero normal component counts as
	// non-negative and picks the max corner, and an inverted box is taken as it
	// stands, with no swapping of its corners.
	function automatic logic predict_visible(fcull_pkg::item_t it);
		longint pa[3];
		longint pb[3];
		longint nrm[3];
		longint acc;
		logic vis;
		vis = 1'b1;
		pa[0] = longint'($signed(it.point_a_x));
		pa[1] = longint'($signed(it.point_a_y));
		pa[2] = longint'($signed(it.point_a_z));
		pb[0] = longint'($signed(it.point_b_x));
		pb[1] = longint'($signed(it.point_b_y));
		pb[2] = longint'($signed(it.point_b_z));
		for (int i = 0; i < fcull_pkg::NUM_PLANES; i++) begin
			nrm[0] = longint'($signed(plane_regs[i].nx));
			nrm[1] = longint'($signed(plane_regs[i].ny));
			nrm[2] = longint'($signed(plane_regs[i].nz));
			acc = longint'($signed(plane_regs[i].distance)) * NORM_ONE;
			for (int k = 0; k < 3; k++) begin
				if (it.mode == fcull_pkg::MODE_SPHERE)
					acc += nrm[k] * pa[k];
				else
					acc += nrm[k] * ((nrm[k] >= 0) ? pb[k] : pa[k]);
			end
			if (it.mode == fcull_pkg::MODE_SPHERE)
				acc += longint'(it.radius) * NORM_ONE;
			if (acc < 0)
				vis = 1'b0;
		end
		return vis;
	endfunction

	// Packs a plane; each value is cut to its field width.
	function automatic logic [fcull_pkg::DATA_W-1:0] make_plane(int nx, int ny, int nz,
			int distance);
		fcull_pkg::plane_t pl;
		pl.nx = fcull_pkg::NORM_W'(nx);
		pl.ny = fcull_pkg::NORM_W'(ny);
		pl.nz = fcull_pkg::NORM_W'(nz);
		pl.distance = fcull_pkg::DIST_W'(distance);
		return pl;
	endfunction

	// APB write: setup cycle, then access cycle; the register is taken at the
	// edge where the access phase meets pready. The bus then idles, so that
	// back-to-back writes never reassign psel within one time step.
	task automatic write_plane(plane_reg_t idx, logic [fcull_pkg::DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= fcull_pkg::ADDR_W'(int'(idx) << fcull_pkg::REG_LSB);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (int'(idx) < fcull_pkg::PLANE_REGS)
			plane_regs[int'(idx)] = fcull_pkg::plane_t'(value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Offers one request, with random idle cycles in front of it unless the
	// calm flag is set, and records its predicted verdict on acceptance.
	task automatic send_request(fcull_pkg::item_t it);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		mode <= it.mode;
		point_a_x <= it.point_a_x;
		point_a_y <= it.point_a_y;
		point_a_z <= it.point_a_z;
		point_b_x <= it.point_b_x;
		point_b_y <= it.point_b_y;
		point_b_z <= it.point_b_z;
		radius <= it.radius;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		visible_q.push_back(predict_visible(it));
		@(negedge clk);
	endtask

	// Stops offering requests and waits for every owed verdict.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (visible_q.size() != 0)
			@(negedge clk);
	endtask

	// Planes may only change with the pipeline empty, since the cells read
	// the registers directly; give it the full depth after the last verdict.
	task automatic settle_pipeline();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic fcull_pkg::item_t sphere_req(int x, int y, int z, int r);
		fcull_pkg::item_t it;
		it.mode = fcull_pkg::MODE_SPHERE;
		it.point_a_x = coord_t'(x);
		it.point_a_y = coord_t'(y);
		it.point_a_z = coord_t'(z);
		it.point_b_x = coord_t'($urandom);
		it.point_b_y = coord_t'($urandom);
		it.point_b_z = coord_t'($urandom);
		it.radius = fcull_pkg::RADIUS_W'(r);
		return it;
	endfunction

	function automatic fcull_pkg::item_t box_req(int ax, int ay, int az,
			int bx, int by, int bz);
		fcull_pkg::item_t it;
		it.mode = fcull_pkg::MODE_BOX;
		it.point_a_x = coord_t'(ax);
		it.point_a_y = coord_t'(ay);
		it.point_a_z = coord_t'(az);
		it.point_b_x = coord_t'(bx);
		it.point_b_y = coord_t'(by);
		it.point_b_z = coord_t'(bz);
		it.radius = fcull_pkg::RADIUS_W'($urandom);
		return it;
	endfunction

	// Coordinates mostly of a random magnitude, so that small and large
	// values both turn up; a fifth are raw bit patterns.
	function automatic coord_t rand_coord();
		int mag;
		if ($urandom_range(4) == 0)
			return coord_t'($urandom);
		mag = $urandom & ((1 << $urandom_range(fcull_pkg::COORD_W - 1)) - 1);
		return coord_t'($urandom_range(1) ? -mag : mag);
	endfunction

	// Upper corner of a well-formed box: the lower corner plus a non-negative
	// extent, held at the top of the range.
	function automatic coord_t box_upper(coord_t lo);
		int hi;
		hi = int'(lo) + ($urandom & ((1 << $urandom_range(21)) - 1));
		if (hi > COORD_MAX)
			hi = COORD_MAX;
		return coord_t'(hi);
	endfunction

	function automatic logic [fcull_pkg::RADIUS_W-1:0] rand_radius();
		if ($urandom_range(4) == 0)
			return fcull_pkg::RADIUS_W'($urandom);
		return fcull_pkg::RADIUS_W'($urandom &
			((1 << $urandom_range(fcull_pkg::RADIUS_W)) - 1));
	endfunction

	// Most boxes are well formed; the rest have independent, often inverted,
	// corners.
	function automatic fcull_pkg::item_t rand_request();
		fcull_pkg::item_t it;
		it.mode = $urandom_range(1) ? fcull_pkg::MODE_BOX : fcull_pkg::MODE_SPHERE;
		it.point_a_x = rand_coord();
		it.point_a_y = rand_coord();
		it.point_a_z = rand_coord();
		if ($urandom_range(99) < 85) begin
			it.point_b_x = box_upper(it.point_a_x);
			it.point_b_y = box_upper(it.point_a_y);
			it.point_b_z = box_upper(it.point_a_z);
		end else begin
			it.point_b_x = rand_coord();
			it.point_b_y = rand_coord();
			it.point_b_z = rand_coord();
		end
		it.radius = rand_radius();
		return it;
	endfunction

	// A random plane: some are cleared, a few are raw bits, and the rest have
	// a random normal and a distance of random size leaning positive, so that
	// a fair share of objects survive all six tests.
	function automatic logic [fcull_pkg::DATA_W-1:0] rand_plane();
		int distance;
		case ($urandom_range(9))
			0: return '0;
			1: return {$urandom, $urandom};
			default: begin
				distance = $urandom & ((1 << $urandom_range(fcull_pkg::DIST_W - 1)) - 1);
				if ($urandom_range(99) < 30)
					distance = -distance;
				return make_plane(int'($urandom), int'($urandom), int'($urandom),
					distance);
			end
		endcase
	endfunction

	// Planes are still cleared from reset, so nothing may be culled, even
	// objects at the very corners of the coordinate range.
	task automatic test_reset_planes();
		send_request(sphere_req(COORD_MIN, COORD_MIN, COORD_MIN, 0));
		send_request(sphere_req(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX));
		send_request(box_req(COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MIN, COORD_MIN));
	endtask

	// A cube of side 2000 units round the origin, one axis per plane pair.
	// Every normal has two zero components, so the zero-normal rule picks the
	// max corner on those axes. Exact touching must count as visible.
	task automatic test_axis_box();
		settle_pipeline();
		write_plane(REG_LEFT,   make_plane(NORM_ONE, 0, 0, HALF_SIDE));
		write_plane(REG_RIGHT,  make_plane(-NORM_ONE, 0, 0, HALF_SIDE));
		write_plane(REG_BOTTOM, make_plane(0, NORM_ONE, 0, HALF_SIDE));
		write_plane(REG_TOP,    make_plane(0, -NORM_ONE, 0, HALF_SIDE));
		write_plane(REG_NEAR,   make_plane(0, 0, NORM_ONE, HALF_SIDE));
		write_plane(REG_FAR,    make_plane(0, 0, -NORM_ONE, HALF_SIDE));
		calm = 1'b0;
		send_request(sphere_req(0, 0, 0, 0));
		send_request(sphere_req(-HALF_SIDE - UNIT, 0, 0, 0));
		send_request(sphere_req(-HALF_SIDE - UNIT, 0, 0, UNIT));
		send_request(sphere_req(-HALF_SIDE - 1, 0, 0, 0));
		send_request(sphere_req(0, 0, HALF_SIDE + 1, 0));
		send_request(sphere_req(COORD_MAX, 0, 0, 0));
		send_request(sphere_req(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX));
		send_request(sphere_req(0, HALF_SIDE + RADIUS_MAX, 0, RADIUS_MAX));
		send_request(box_req(-2 * HALF_SIDE, 0, 0, -3 * HALF_SIDE / 2, UNIT, UNIT));
		send_request(box_req(-2 * HALF_SIDE, 0, 0, 0, UNIT, UNIT));
		// Inverted on x: the left plane takes point b's x, here the smaller one, which lies outside.
		send_request(box_req(HALF_SIDE / 2, 0, 0, -3 * HALF_SIDE / 2, UNIT, UNIT));
		send_request(box_req(COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MAX, COORD_MAX, COORD_MAX));
		send_request(box_req(COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MIN, COORD_MIN));
		send_request(box_req(-HALF_SIDE, -HALF_SIDE, -HALF_SIDE, -HALF_SIDE,
			-HALF_SIDE, -HALF_SIDE));
	endtask

	// Normals and distances at the ends of their ranges, an all-ones plane,
	// and writes past the last register, which must change nothing.
	task automatic test_extreme_planes();
		settle_pipeline();
		write_plane(REG_LEFT,   make_plane(-2048, 2047, 0, DIST_MAX));
		write_plane(REG_RIGHT,  make_plane(2047, -2048, -2048, DIST_MAX));
		write_plane(REG_BOTTOM, '0);
		write_plane(REG_TOP,    make_plane(2047, 2047, 2047, DIST_MAX));
		write_plane(REG_NEAR,   '0);
		write_plane(REG_FAR,    '0);
		write_plane(REG_HOLE_0, {fcull_pkg::DATA_W{1'b1}});
		write_plane(REG_HOLE_1, make_plane(2047, 0, 0, DIST_MIN));
		send_request(sphere_req(COORD_MAX, COORD_MIN, COORD_MAX, 0));
		send_request(sphere_req(COORD_MIN, COORD_MAX, COORD_MIN, RADIUS_MAX));
		send_request(box_req(COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MAX, COORD_MAX, COORD_MAX));
		settle_pipeline();
		write_plane(REG_FAR, {fcull_pkg::DATA_W{1'b1}});
		send_request(sphere_req(0, 0, 0, RADIUS_MAX));
		send_request(box_req(COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX));
	endtask

	// Random streams under several plane settings. One phase sets only corner
	// planes, one runs a long calm stretch with no idling, and one makes the
	// sender stop until every owed verdict has come back.
	task automatic test_random_stream();
		for (int ph = 0; ph < PHASES; ph++) begin
			settle_pipeline();
			for (int i = 0; i < fcull_pkg::PLANE_REGS; i++) begin
				if (ph != 1) begin
					write_plane(plane_reg_t'(i), rand_plane());
				end else begin
					case ($urandom_range(4))
						0: write_plane(plane_reg_t'(i), {fcull_pkg::DATA_W{1'b1}});
						1: write_plane(plane_reg_t'(i), '0);
						2: write_plane(plane_reg_t'(i),
							make_plane(2047, 2047, 2047, DIST_MAX));
						3: write_plane(plane_reg_t'(i),
							make_plane(-2048, -2048, -2048, DIST_MIN));
						default: write_plane(plane_reg_t'(i),
							make_plane(-2048, 0, 2047, DIST_MAX));
					endcase
				end
			end
			if (ph == 4)
				write_plane(REG_HOLE_0, rand_plane());
			calm = (ph == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == PHASE_ITEMS / 2)
					calm = 1'b0;
				if (ph == 3 && n == PHASE_ITEMS / 2)
					wait_for_results();
				send_request(rand_request());
			end
			calm = 1'b0;
		end
	endtask

	// The receiver stalls at random in step with the sender's idling.
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// Every accepted result is matched against the oldest owed verdict.
	always @(posedge clk) begin
		logic want;
		if (arst_n && out_valid && out_ready) begin
			if (visible_q.size() == 0) begin
				report_mismatch($sformatf("result %0d came with no request outstanding",
					result_count));
			end else begin
				want = visible_q.pop_front();
				if (visible !== want)
					report_mismatch($sformatf("result %0d: visible %b, predicted %b",
						result_count, visible, want));
			end
			result_count++;
		end
	end

	initial begin
		foreach (plane_regs[i])
			plane_regs[i] = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_planes();
		test_axis_box();
		test_extreme_planes();
		test_random_stream();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("frustum_cull_sphere_aabb_core_test: done, clean");
		else
			$display("frustum_cull_sphere_aabb_core_test: done, errors");
		$finish;
	end

endmodule
